@@ src/msaa_pkg.sv @@
package msaa_pkg;

    localparam int NODE_DEPTH_DEF  = 4096;
    localparam int COORD_WIDTH_DEF = 24;

    localparam int IDX_W   = 12;
    localparam int FIELD_W = 24;
    localparam int AREA_W  = 50;
    localparam int TOTAL_W = 64;
    localparam int COUNT_W = 32;
    localparam int SPA_W   = 32;

    localparam logic [SPA_W-1:0]  SPA_RESET = 32'h0001_0000;
    localparam logic [AREA_W-1:0] AREA_MAX  = {AREA_W{1'b1}};

    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_TRI    = 2'd1,
        CMD_QUAD   = 2'd2,
        CMD_REPORT = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd                      command;
        logic [IDX_W-1:0]          node_index;
        logic signed [FIELD_W-1:0] coord_x;
        logic signed [FIELD_W-1:0] coord_y;
        logic signed [FIELD_W-1:0] coord_z;
        logic [IDX_W-1:0]          corner_a;
        logic [IDX_W-1:0]          corner_b;
        logic [IDX_W-1:0]          corner_c;
        logic [IDX_W-1:0]          corner_d;
    } t_in_req;

    typedef struct packed {
        logic [AREA_W-1:0]  item_area;
        logic [TOTAL_W-1:0] total_area;
        logic [COUNT_W-1:0] sample_count;
    } t_out_rsp;

endpackage

@@ src/msaa_area.sv @@
module msaa_area #(
    parameter int COORD_WIDTH = msaa_pkg::COORD_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [3*COORD_WIDTH-1:0]     i_node_a,
    input  logic [3*COORD_WIDTH-1:0]     i_node_b,
    input  logic [3*COORD_WIDTH-1:0]     i_node_c,
    output logic                         o_done,
    output logic [msaa_pkg::AREA_W-1:0]  o_area
);
    import msaa_pkg::*;

    localparam int W     = COORD_WIDTH;
    localparam int DW    = W + 1;
    localparam int PW    = 2 * DW;
    localparam int CW    = 2 * W + 2;
    localparam int NW    = 4 * W + 4;
    localparam int RW    = CW;
    localparam int HW    = RW - 1;
    localparam int XW    = (HW > AREA_W) ? HW : AREA_W;
    localparam int CNT_W = $clog2(CW + 1);

    localparam logic [2:0] STEP_SETUP = 3'd7;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_SQ,
        S_ROOT,
        S_OUT
    } t_state;

    t_state                r_state;
    logic [2:0]            r_step;
    logic signed [DW-1:0]  r_ux, r_uy, r_uz, r_vx, r_vy, r_vz;
    logic signed [PW-1:0]  r_prod;
    logic signed [PW-1:0]  r_tmp;
    logic [CW-1:0]         r_c0, r_c1, r_c2;
    logic [NW-1:0]         r_mcand;
    logic [CW-1:0]         r_mplier;
    logic [NW-1:0]         r_n;
    logic [CNT_W-1:0]      r_cnt;
    logic [1:0]            r_comp;
    logic [RW:0]           r_rem;
    logic [RW-1:0]         r_root;
    logic                  r_done;
    logic [AREA_W-1:0]     r_area;

    logic signed [DW-1:0]  w_op1, w_op2;
    logic signed [PW-1:0]  w_prod;
    logic signed [PW:0]    w_diff;
    logic signed [PW:0]    w_abs;
    logic [RW+1:0]         w_rs;
    logic [RW+1:0]         w_trial;
    logic [RW+1:0]         w_rs_sub;
    logic [HW-1:0]         w_half;
    logic [XW-1:0]         w_half_x;

    // operand pairs of the three cross product components, two terms each
    always_comb begin
        unique case (r_step)
            3'd0:    begin w_op1 = r_uy; w_op2 = r_vz; end
            3'd1:    begin w_op1 = r_uz; w_op2 = r_vy; end
            3'd2:    begin w_op1 = r_uz; w_op2 = r_vx; end
            3'd3:    begin w_op1 = r_ux; w_op2 = r_vz; end
            3'd4:    begin w_op1 = r_ux; w_op2 = r_vy; end
            3'd5:    begin w_op1 = r_uy; w_op2 = r_vx; end
            default: begin w_op1 = r_ux; w_op2 = r_vx; end
        endcase
    end

    assign w_prod   = w_op1 * w_op2;
    assign w_diff   = (PW+1)'(r_tmp) - (PW+1)'(r_prod);
    assign w_abs    = w_diff[PW] ? -w_diff : w_diff;

    assign w_rs     = {r_rem[RW-1:0], r_n[NW-1 -: 2]};
    assign w_trial  = {r_root, 2'b01};
    assign w_rs_sub = w_rs - w_trial;

    assign w_half   = r_root[RW-1:1];
    assign w_half_x = XW'(w_half);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= (r_state == S_OUT);
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_ux   <= DW'(signed'(i_node_b[3*W-1 -: W]))
                                - DW'(signed'(i_node_a[3*W-1 -: W]));
                        r_uy   <= DW'(signed'(i_node_b[2*W-1 -: W]))
                                - DW'(signed'(i_node_a[2*W-1 -: W]));
                        r_uz   <= DW'(signed'(i_node_b[W-1:0]))
                                - DW'(signed'(i_node_a[W-1:0]));
                        r_vx   <= DW'(signed'(i_node_c[3*W-1 -: W]))
                                - DW'(signed'(i_node_a[3*W-1 -: W]));
                        r_vy   <= DW'(signed'(i_node_c[2*W-1 -: W]))
                                - DW'(signed'(i_node_a[2*W-1 -: W]));
                        r_vz   <= DW'(signed'(i_node_c[W-1:0]))
                                - DW'(signed'(i_node_a[W-1:0]));
                        r_step  <= 3'd0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    // the product is registered before use: odd steps keep the first
                    // term, even steps store the magnitude of the difference
                    r_prod <= w_prod;
                    r_step <= r_step + 3'd1;
                    if (r_step == STEP_SETUP) begin
                        r_mcand  <= NW'(r_c0);
                        r_mplier <= r_c0;
                        r_n      <= '0;
                        r_comp   <= 2'd0;
                        r_cnt    <= CNT_W'(CW - 1);
                        r_state  <= S_SQ;
                    end else if (r_step[0]) begin
                        r_tmp <= r_prod;
                    end else if (r_step != 3'd0) begin
                        r_c0 <= r_c1;
                        r_c1 <= r_c2;
                        r_c2 <= w_abs[CW-1:0];
                    end
                end
                S_SQ: begin
                    // shift-and-add square, summed straight into the radicand
                    if (r_mplier[0]) begin
                        r_n <= r_n + r_mcand;
                    end
                    if (r_cnt == '0) begin
                        if (r_comp == 2'd2) begin
                            r_rem   <= '0;
                            r_root  <= '0;
                            r_cnt   <= CNT_W'(RW - 1);
                            r_state <= S_ROOT;
                        end else begin
                            r_c0     <= r_c1;
                            r_c1     <= r_c2;
                            r_c2     <= r_c0;
                            r_mcand  <= NW'(r_c1);
                            r_mplier <= r_c1;
                            r_comp   <= r_comp + 2'd1;
                            r_cnt    <= CNT_W'(CW - 1);
                        end
                    end else begin
                        r_mcand  <= r_mcand << 1;
                        r_mplier <= r_mplier >> 1;
                        r_cnt    <= r_cnt - 1'b1;
                    end
                end
                S_ROOT: begin
                    // restoring square root, one result bit per cycle
                    if (w_rs >= w_trial) begin
                        r_rem  <= w_rs_sub[RW:0];
                        r_root <= {r_root[RW-2:0], 1'b1};
                    end else begin
                        r_rem  <= w_rs[RW:0];
                        r_root <= {r_root[RW-2:0], 1'b0};
                    end
                    r_n   <= r_n << 2;
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    r_area  <= (w_half_x > XW'(AREA_MAX)) ? AREA_MAX
                                                          : w_half_x[AREA_W-1:0];
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_area = r_area;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> (r_state == S_IDLE))
        else $error("area unit started while busy");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("area done held for more than one cycle");

    a_root_after_squares: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROOT) |-> (r_comp == 2'd2))
        else $error("root started before all three squares were summed");

endmodule

@@ src/mesh_surface_area_accumulator.sv @@
// Mesh surface area accumulator.
// Input channel (i_in_valid / o_in_ready / i_in_req) takes one request at a time:
// load node, triangle, quadrangle, or report-and-clear. Each request gives
// exactly one response on the output channel (o_out_valid / i_out_ready /
// o_out_rsp). samples_per_area is written through i_cfg_we / i_cfg_wdata; the
// user must write it only while the block is idle: the block does not enforce
// this. Triangle and quadrangle time is set by the bit-serial squarer and the
// one-bit-per-cycle square root in msaa_area; the node store has one read
// port, so the corners are fetched one per cycle.
// The response sits in an output register; a new request is taken while it
// waits. If the receiver still stalls when the next response is ready, the
// block holds it and takes no further request.
// Reset clears the running total and sets samples_per_area to 1.0. The node
// store is not cleared: every node must be loaded before an element uses it.
module mesh_surface_area_accumulator #(
    parameter int NODE_DEPTH  = msaa_pkg::NODE_DEPTH_DEF,
    parameter int COORD_WIDTH = msaa_pkg::COORD_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  msaa_pkg::t_in_req           i_in_req,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output msaa_pkg::t_out_rsp          o_out_rsp,
    input  logic                        i_cfg_we,
    input  logic [msaa_pkg::SPA_W-1:0]  i_cfg_wdata
);
    import msaa_pkg::*;

    localparam int AW  = $clog2(NODE_DEPTH);
    localparam int NDW = 3 * COORD_WIDTH;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RDA,
        S_RDB,
        S_RDC,
        S_RDW,
        S_AREA,
        S_ACC,
        S_RPT0,
        S_RPT1,
        S_RPT2,
        S_DONE
    } t_state;

    t_state               r_state;
    t_in_req              r_req;
    logic                 r_tri;
    logic [AREA_W-1:0]    r_item;
    logic [TOTAL_W-1:0]   r_total;
    logic [COUNT_W-1:0]   r_count;
    logic [SPA_W-1:0]     r_spa;
    logic [63:0]          r_plo;
    logic [63:0]          r_phi;
    logic [NDW-1:0]       r_na;
    logic [NDW-1:0]       r_nb;
    logic                 r_out_valid;
    t_out_rsp             r_out;

    logic [NDW-1:0]       r_node_mem [NODE_DEPTH];
    logic [NDW-1:0]       r_rd_data;
    logic                 r_rd_ok;

    logic                 w_accept;
    logic                 w_wr_en;
    logic [AW-1:0]        w_wr_addr;
    logic [NDW-1:0]       w_wr_data;
    logic [IDX_W-1:0]     w_rd_idx;
    logic                 w_rd_ok;
    logic [NDW-1:0]       w_node;
    logic                 w_start;
    logic                 w_area_done;
    logic [AREA_W-1:0]    w_area;
    logic [AREA_W:0]      n_sum;
    logic [TOTAL_W:0]     n_tot;
    logic [31:0]          w_mop;
    logic [63:0]          w_mul;
    logic [63:0]          w_lo;
    logic [32:0]          n_cnt;
    logic                 w_out_free;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;

    // node store: one write port for loads, one registered read port
    assign w_wr_en   = w_accept && (i_in_req.command == CMD_LOAD)
                     && (32'(i_in_req.node_index) < 32'(NODE_DEPTH));
    assign w_wr_addr = AW'(i_in_req.node_index);
    assign w_wr_data = {COORD_WIDTH'({{(32-FIELD_W){1'b0}}, i_in_req.coord_x}),
                        COORD_WIDTH'({{(32-FIELD_W){1'b0}}, i_in_req.coord_y}),
                        COORD_WIDTH'({{(32-FIELD_W){1'b0}}, i_in_req.coord_z})};

    always_comb begin
        unique case (r_state)
            S_RDB:   w_rd_idx = r_req.corner_b;
            S_RDC:   w_rd_idx = r_tri ? r_req.corner_d : r_req.corner_c;
            default: w_rd_idx = r_req.corner_a;
        endcase
    end

    assign w_rd_ok = (32'(w_rd_idx) < 32'(NODE_DEPTH));

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_node_mem[w_wr_addr] <= w_wr_data;
        end
        r_rd_data <= r_node_mem[AW'(w_rd_idx)];
        r_rd_ok   <= w_rd_ok;
    end

    // a corner beyond the store reads as the origin
    assign w_node  = r_rd_ok ? r_rd_data : '0;
    assign w_start = (r_state == S_RDW);

    msaa_area #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_area (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_start),
        .i_node_a (r_na),
        .i_node_b (r_nb),
        .i_node_c (w_node),
        .o_done   (w_area_done),
        .o_area   (w_area)
    );

    assign n_sum = {1'b0, r_item} + {1'b0, w_area};
    assign n_tot = {1'b0, r_total} + (TOTAL_W+1)'(r_item);

    // sample count: two 32x32 products, low half first, with half-up rounding
    assign w_mop = (r_state == S_RPT0) ? r_total[31:0] : r_total[63:32];
    assign w_mul = w_mop * r_spa;
    assign w_lo  = r_plo + 64'h0000_0000_8000_0000;
    assign n_cnt = {1'b0, r_phi[31:0]} + {1'b0, w_lo[63:32]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_total     <= '0;
            r_spa       <= SPA_RESET;
        end else begin
            if (i_cfg_we) begin
                r_spa <= i_cfg_wdata;
            end
            // in S_DONE the output register is reloaded below instead
            if (r_out_valid && i_out_ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_req   <= i_in_req;
                        r_item  <= '0;
                        r_count <= '0;
                        r_tri   <= 1'b0;
                        unique case (i_in_req.command)
                            CMD_LOAD:   r_state <= S_DONE;
                            CMD_REPORT: r_state <= S_RPT0;
                            default:    r_state <= S_RDA;
                        endcase
                    end
                end
                S_RDA: r_state <= S_RDB;
                S_RDB: begin
                    r_na    <= w_node;
                    r_state <= S_RDC;
                end
                S_RDC: begin
                    r_nb    <= w_node;
                    r_state <= S_RDW;
                end
                S_RDW: r_state <= S_AREA;
                S_AREA: begin
                    if (w_area_done) begin
                        if (!r_tri) begin
                            r_item <= w_area;
                            if (r_req.command == CMD_QUAD) begin
                                r_tri   <= 1'b1;
                                r_state <= S_RDA;
                            end else begin
                                r_state <= S_ACC;
                            end
                        end else begin
                            r_item  <= n_sum[AREA_W] ? AREA_MAX : n_sum[AREA_W-1:0];
                            r_state <= S_ACC;
                        end
                    end
                end
                S_ACC: begin
                    r_total <= n_tot[TOTAL_W] ? {TOTAL_W{1'b1}} : n_tot[TOTAL_W-1:0];
                    r_state <= S_DONE;
                end
                S_RPT0: begin
                    r_plo   <= w_mul;
                    r_state <= S_RPT1;
                end
                S_RPT1: begin
                    r_phi   <= w_mul;
                    r_state <= S_RPT2;
                end
                S_RPT2: begin
                    r_count <= ((r_phi[63:32] != '0) || n_cnt[32]) ? {COUNT_W{1'b1}}
                                                                  : n_cnt[31:0];
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_out.item_area    <= r_item;
                        r_out.total_area   <= r_total;
                        r_out.sample_count <= r_count;
                        r_out_valid        <= 1'b1;
                        if (r_req.command == CMD_REPORT) begin
                            r_total <= '0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_in_ready)
        else $error("request taken while the previous one is in flight");

    a_report_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_req.command == CMD_REPORT && w_out_free)
        |=> (r_total == '0))
        else $error("total not cleared after report");

    a_total_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ACC) |=> (r_total >= $past(r_total)))
        else $error("total decreased on accumulation");

endmodule

@@ dv/tb_mesh_surface_area_accumulator.sv @@
module tb_mesh_surface_area_accumulator;
    import msaa_pkg::*;

    localparam int DEPTH      = NODE_DEPTH_DEF;
    localparam int STALL_LEN  = 1500;
    localparam int WDOG_LIMIT = 20000;
    localparam int PHASE_ITEMS = 630;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    t_in_req            i_in_req = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    t_out_rsp           o_out_rsp;
    logic               i_cfg_we = 1'b0;
    logic [SPA_W-1:0]   i_cfg_wdata = '0;

    mesh_surface_area_accumulator u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_rsp   (o_out_rsp),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state
    logic signed [FIELD_W-1:0] node_x [DEPTH];
    logic signed [FIELD_W-1:0] node_y [DEPTH];
    logic signed [FIELD_W-1:0] node_z [DEPTH];
    logic [TOTAL_W-1:0]        run_total = '0;
    logic [SPA_W-1:0]          spa_now = SPA_RESET;

    // stimulus bookkeeping: which nodes have a load queued
    bit        node_loaded [DEPTH];
    int        loaded_list [$];

    t_in_req   req_backlog [$];
    t_out_rsp  owed_rsp [$];

    int  send_idle = 0, recv_idle = 0;
    bit  send_pause = 0, stall_req = 0;
    int  mismatches = 0, reqs_done = 0, rsps_done = 0, reports_seen = 0;
    int  quiet_cycles = 0;

    // squares of the trial roots need more than 128 bits
    function automatic logic [127:0] isqrt(logic [127:0] n);
        logic [127:0] root, cand;
        logic [255:0] sq;
        root = '0;
        for (int b = 67; b >= 0; b--) begin
            cand = root | (128'd1 << b);
            sq   = 256'(cand) * 256'(cand);
            if (sq <= 256'(n)) root = cand;
        end
        return root;
    endfunction

    function automatic logic [AREA_W-1:0] tri_area_q16(int ia, int ib, int ic);
        logic signed [127:0] ux, uy, uz, vx, vy, vz, cx, cy, cz;
        logic [127:0] root, half;
        ux = node_x[ib]; ux = ux - node_x[ia];
        uy = node_y[ib]; uy = uy - node_y[ia];
        uz = node_z[ib]; uz = uz - node_z[ia];
        vx = node_x[ic]; vx = vx - node_x[ia];
        vy = node_y[ic]; vy = vy - node_y[ia];
        vz = node_z[ic]; vz = vz - node_z[ia];
        cx = uy * vz - uz * vy;
        cy = uz * vx - ux * vz;
        cz = ux * vy - uy * vx;
        root = isqrt(cx * cx + cy * cy + cz * cz);
        half = root >> 1;
        return (half > 128'(AREA_MAX)) ? AREA_MAX : half[AREA_W-1:0];
    endfunction

    function automatic t_out_rsp predict_rsp(t_in_req r);
        t_out_rsp     p;
        logic [127:0] wide;
        p = '0;
        case (r.command)
            CMD_LOAD: begin
                node_x[r.node_index] = r.coord_x;
                node_y[r.node_index] = r.coord_y;
                node_z[r.node_index] = r.coord_z;
                p.total_area = run_total;
            end
            CMD_REPORT: begin
                p.total_area = run_total;
                wide = (128'(run_total) * 128'(spa_now) + 128'h8000_0000) >> 32;
                p.sample_count = (wide > 128'hFFFF_FFFF) ? '1 : wide[COUNT_W-1:0];
                run_total = '0;
            end
            default: begin
                wide = 128'(tri_area_q16(r.corner_a, r.corner_b, r.corner_c));
                if (r.command == CMD_QUAD)
                    wide += 128'(tri_area_q16(r.corner_a, r.corner_b, r.corner_d));
                if (wide > 128'(AREA_MAX)) wide = 128'(AREA_MAX);
                p.item_area = wide[AREA_W-1:0];
                wide = 128'(run_total) + wide;
                run_total = (wide > 128'hFFFF_FFFF_FFFF_FFFF) ? '1 : wide[TOTAL_W-1:0];
                p.total_area = run_total;
            end
        endcase
        return p;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        mismatches++;
        $display("ERROR %s: got %0h expected %0h (response %0d)", what, got, want, rsps_done);
    endtask

    // driver
    always @(posedge i_clk) begin
        t_in_req nxt;
        logic    nv;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_in_req   <= '0;
        end else begin
            nxt = i_in_req;
            nv  = i_in_valid;
            if (i_in_valid && o_in_ready) begin
                owed_rsp.push_back(predict_rsp(i_in_req));
                reqs_done++;
                nv = 1'b0;
            end
            if (!nv && req_backlog.size() > 0 && !send_pause
                    && $urandom_range(99) >= send_idle) begin
                nxt = req_backlog.pop_front();
                nv  = 1'b1;
            end
            i_in_valid <= nv;
            i_in_req   <= nxt;
        end
    end

    // receiver, with an occasional long hold-off
    always @(posedge i_clk) begin
        int hold_left;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            hold_left = 0;
        end else begin
            if (stall_req) begin
                stall_req = 0;
                hold_left = STALL_LEN;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_idle);
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_out_rsp want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (owed_rsp.size() == 0) begin
                report_mismatch("unexpected response", o_out_rsp.total_area, '0);
            end else begin
                want = owed_rsp.pop_front();
                if (o_out_rsp.item_area !== want.item_area)
                    report_mismatch("item_area", 64'(o_out_rsp.item_area),
                                    64'(want.item_area));
                if (o_out_rsp.total_area !== want.total_area)
                    report_mismatch("total_area", o_out_rsp.total_area, want.total_area);
                if (o_out_rsp.sample_count !== want.sample_count)
                    report_mismatch("sample_count", 64'(o_out_rsp.sample_count),
                                    64'(want.sample_count));
                if (want.sample_count != 0) reports_seen++;
            end
            rsps_done++;
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WDOG_LIMIT) begin
            $display("Watchdog expired: %0d requests, %0d responses", reqs_done, rsps_done);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic logic signed [FIELD_W-1:0] rnd_coord();
        case ($urandom_range(3))
            0: return FIELD_W'($urandom_range(2000) - 1000);
            1: return $urandom_range(1) ? 24'sh7FFFFF : 24'sh800000;
            default: return FIELD_W'($urandom);
        endcase
    endfunction

    function automatic t_in_req mk_load(int idx, logic signed [FIELD_W-1:0] x,
                                        logic signed [FIELD_W-1:0] y,
                                        logic signed [FIELD_W-1:0] z);
        t_in_req r;
        r = '0;
        r.corner_a = IDX_W'($urandom); r.corner_b = IDX_W'($urandom);
        r.corner_c = IDX_W'($urandom); r.corner_d = IDX_W'($urandom);
        r.command = CMD_LOAD;
        r.node_index = IDX_W'(idx);
        r.coord_x = x; r.coord_y = y; r.coord_z = z;
        if (!node_loaded[idx]) begin
            node_loaded[idx] = 1;
            loaded_list.push_back(idx);
        end
        return r;
    endfunction

    function automatic t_in_req mk_elem(t_cmd c, int a, int b, int cc, int d);
        t_in_req r;
        r.command = c;
        r.node_index = IDX_W'($urandom);
        r.coord_x = FIELD_W'($urandom);
        r.coord_y = FIELD_W'($urandom);
        r.coord_z = FIELD_W'($urandom);
        r.corner_a = IDX_W'(a); r.corner_b = IDX_W'(b); r.corner_c = IDX_W'(cc);
        // fourth corner is ignored on a triangle, so anything goes there
        r.corner_d = (c == CMD_QUAD) ? IDX_W'(d) : IDX_W'($urandom);
        return r;
    endfunction

    function automatic int any_node();
        return loaded_list[$urandom_range(loaded_list.size() - 1)];
    endfunction

    function automatic t_in_req rnd_req();
        int k;
        k = $urandom_range(99);
        if (k < 30) begin
            // mostly a small working set, sometimes anywhere in the store
            return mk_load($urandom_range(3) == 0 ? $urandom_range(DEPTH - 1)
                                                  : $urandom_range(63),
                           rnd_coord(), rnd_coord(), rnd_coord());
        end else if (k < 60) begin
            return mk_elem(CMD_TRI, any_node(), any_node(), any_node(), 0);
        end else if (k < 90) begin
            return mk_elem(CMD_QUAD, any_node(), any_node(), any_node(), any_node());
        end else if (k < 95) begin
            return mk_elem(CMD_REPORT, $urandom, $urandom, $urandom, $urandom);
        end else begin
            // degenerate: repeated corner
            k = any_node();
            return mk_elem(CMD_TRI, k, k, any_node(), 0);
        end
    endfunction

    task automatic drain();
        while (req_backlog.size() > 0 || i_in_valid || owed_rsp.size() > 0)
            @(posedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic write_spa(logic [SPA_W-1:0] v);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        spa_now = v;
    endtask

    localparam logic signed [FIELD_W-1:0] CMAX = 24'sh7FFFFF;
    localparam logic signed [FIELD_W-1:0] CMIN = 24'sh800000;

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extreme nodes, big and tiny elements, report at full density
        write_spa('1);
        req_backlog.push_back(mk_load(0, CMIN, CMIN, CMIN));
        req_backlog.push_back(mk_load(1, CMAX, CMIN, CMIN));
        req_backlog.push_back(mk_load(2, CMIN, CMAX, CMIN));
        req_backlog.push_back(mk_load(3, CMIN, CMIN, CMAX));
        req_backlog.push_back(mk_load(4, CMAX, CMAX, CMAX));
        req_backlog.push_back(mk_load(5, 24'sd0, 24'sd0, 24'sd0));
        req_backlog.push_back(mk_load(6, 24'sd1, 24'sd0, 24'sd0));
        req_backlog.push_back(mk_load(DEPTH - 1, 24'sd0, 24'sd1, -24'sd1));
        req_backlog.push_back(mk_load(7, CMAX, CMAX, CMIN));
        req_backlog.push_back(mk_elem(CMD_TRI, 0, 1, 2, 0));
        req_backlog.push_back(mk_elem(CMD_TRI, 1, 2, 3, 0));
        req_backlog.push_back(mk_elem(CMD_QUAD, 1, 2, 3, 0));
        req_backlog.push_back(mk_elem(CMD_QUAD, 0, 4, 7, 1));
        req_backlog.push_back(mk_elem(CMD_QUAD, 4, 0, 1, 7));
        req_backlog.push_back(mk_elem(CMD_TRI, 5, 6, DEPTH - 1, 0));
        req_backlog.push_back(mk_elem(CMD_TRI, 2, 2, 3, 0));
        req_backlog.push_back(mk_elem(CMD_QUAD, 5, 5, 5, 5));
        req_backlog.push_back(mk_elem(CMD_REPORT, 0, 0, 0, 0));
        req_backlog.push_back(mk_elem(CMD_REPORT, 0, 0, 0, 0));
        req_backlog.push_back(mk_elem(CMD_TRI, 0, 1, 3, 0));
        req_backlog.push_back(mk_elem(CMD_REPORT, 0, 0, 0, 0));
        drain();

        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin send_idle = 26; recv_idle = 78; write_spa('0); end
                1: begin send_idle = 78; recv_idle = 26; write_spa($urandom); end
                default: begin send_idle = 0; recv_idle = 0; write_spa(SPA_RESET); end
            endcase
            for (int i = 0; i < PHASE_ITEMS; i++)
                req_backlog.push_back(rnd_req());
            if (ph == 0) begin
                while (req_backlog.size() > PHASE_ITEMS / 2) @(posedge i_clk);
                send_pause = 1;
                while (i_in_valid || owed_rsp.size() > 0) @(posedge i_clk);
                send_pause = 0;
            end
            if (ph == 2) begin
                // fill the block while the output is blocked
                stall_req = 1;
            end
            drain();
        end

        repeat (50) @(posedge i_clk);
        $display("Covered %0d requests / %0d responses over three handshake mixes,",
                 reqs_done, rsps_done);
        $display("%0d non-zero sample counts, densities zero, full, random and unity.",
                 reports_seen);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ sim.f @@
src/msaa_pkg.sv
src/msaa_area.sv
src/mesh_surface_area_accumulator.sv
dv/tb_mesh_surface_area_accumulator.sv
